### hw/rtl/qvr_pkg.sv
package qvr_pkg;

  localparam int CompW  = 16;
  localparam int ProdAW = 2 * CompW;
  localparam int TermW  = ProdAW + 2;
  localparam int ProdCW = TermW + CompW;
  localparam int SumW   = ProdCW + 2;
  localparam int Shift  = 2 * (CompW - 1);
  localparam int WideW  = SumW - Shift;

  localparam logic signed [CompW-1:0] OutMax = {1'b0, {(CompW-1){1'b1}}};
  localparam logic signed [CompW-1:0] OutMin = {1'b1, {(CompW-1){1'b0}}};
  localparam logic signed [SumW-1:0]  RndHalf = SumW'(64'd1 << (Shift - 1));

  typedef logic signed [CompW-1:0]  comp_t;
  typedef logic signed [ProdAW-1:0] proda_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [ProdCW-1:0] prodc_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [WideW-1:0]  wide_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } wide_vec_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  clip;
  } rot_t;

  function automatic proda_t mul_a(comp_t a, comp_t b);
    return proda_t'(a) * proda_t'(b);
  endfunction

  function automatic prodc_t mul_c(term_t a, comp_t b);
    return prodc_t'(a) * prodc_t'(b);
  endfunction

  // round to nearest, ties up, back to the vector scale
  function automatic wide_t round_down(sum_t s);
    sum_t t;
    t = s + RndHalf;
    return WideW'(t >>> Shift);
  endfunction

endpackage

### hw/rtl/qvr_sat.sv
module qvr_sat (
  input  qvr_pkg::wide_vec_t r,
  output qvr_pkg::rot_t      rot
);

  logic [2:0] hi;
  logic [2:0] lo;

  assign hi[0] = r.x > qvr_pkg::WideW'(qvr_pkg::OutMax);
  assign hi[1] = r.y > qvr_pkg::WideW'(qvr_pkg::OutMax);
  assign hi[2] = r.z > qvr_pkg::WideW'(qvr_pkg::OutMax);
  assign lo[0] = r.x < qvr_pkg::WideW'(qvr_pkg::OutMin);
  assign lo[1] = r.y < qvr_pkg::WideW'(qvr_pkg::OutMin);
  assign lo[2] = r.z < qvr_pkg::WideW'(qvr_pkg::OutMin);

  assign rot.x = hi[0] ? qvr_pkg::OutMax : lo[0] ? qvr_pkg::OutMin : qvr_pkg::CompW'(r.x);
  assign rot.y = hi[1] ? qvr_pkg::OutMax : lo[1] ? qvr_pkg::OutMin : qvr_pkg::CompW'(r.y);
  assign rot.z = hi[2] ? qvr_pkg::OutMax : lo[2] ? qvr_pkg::OutMin : qvr_pkg::CompW'(r.z);
  assign rot.clip = |(hi | lo);

endmodule

### hw/rtl/quaternion_vector_rotate_top.sv
// Rotates a vector by a quaternion, giving the vector part of q*v*conj(q) rounded to
// nearest and saturated to 16 bits, with clipped set when any component saturated.
// The quaternion is Q1.15 and is not normalised, so the result scales with its squared
// norm. One word is taken every clock while no stall holds the pipe; it passes through five register
// stages (q*v products, first-stage sums, products with q, sums and rounding, saturation).
// Each stage holds while the one after it is full and stalled, so out_ready reaches
// in_ready combinationally through the stage enables.
module quaternion_vector_rotate_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qvr_pkg::comp_t       quat_x,
  input  qvr_pkg::comp_t       quat_y,
  input  qvr_pkg::comp_t       quat_z,
  input  qvr_pkg::comp_t       quat_w,
  input  qvr_pkg::comp_t       vec_x,
  input  qvr_pkg::comp_t       vec_y,
  input  qvr_pkg::comp_t       vec_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qvr_pkg::comp_t       rot_x,
  output qvr_pkg::comp_t       rot_y,
  output qvr_pkg::comp_t       rot_z,
  output logic                 clipped
);

  logic v_a, v_b, v_c, v_d, v_e;
  logic en_a, en_b, en_c, en_d, en_e;

  qvr_pkg::proda_t   pa [12];
  qvr_pkg::comp_t    qa_x, qa_y, qa_z, qa_w;
  qvr_pkg::term_t    tx, ty, tz, td;
  qvr_pkg::comp_t    qb_x, qb_y, qb_z, qb_w;
  qvr_pkg::prodc_t   pc [12];
  qvr_pkg::wide_vec_t rd;
  qvr_pkg::rot_t     rot_next;
  qvr_pkg::rot_t     rot;

  assign en_e = !v_e || out_ready;
  assign en_d = !v_d || en_e;
  assign en_c = !v_c || en_d;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else begin
      if (en_a) v_a <= in_valid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_d) v_d <= v_c;
      if (en_e) v_e <= v_d;
    end
  end

  // q * (v, 0) products
  always_ff @(posedge clk) begin
    if (en_a) begin
      pa[0]  <= qvr_pkg::mul_a(quat_w, vec_x);
      pa[1]  <= qvr_pkg::mul_a(quat_y, vec_z);
      pa[2]  <= qvr_pkg::mul_a(quat_z, vec_y);
      pa[3]  <= qvr_pkg::mul_a(quat_w, vec_y);
      pa[4]  <= qvr_pkg::mul_a(quat_z, vec_x);
      pa[5]  <= qvr_pkg::mul_a(quat_x, vec_z);
      pa[6]  <= qvr_pkg::mul_a(quat_w, vec_z);
      pa[7]  <= qvr_pkg::mul_a(quat_x, vec_y);
      pa[8]  <= qvr_pkg::mul_a(quat_y, vec_x);
      pa[9]  <= qvr_pkg::mul_a(quat_x, vec_x);
      pa[10] <= qvr_pkg::mul_a(quat_y, vec_y);
      pa[11] <= qvr_pkg::mul_a(quat_z, vec_z);
      qa_x   <= quat_x;
      qa_y   <= quat_y;
      qa_z   <= quat_z;
      qa_w   <= quat_w;
    end
  end

  // td is q.v, the negated scalar part
  always_ff @(posedge clk) begin
    if (en_b) begin
      tx   <= qvr_pkg::TermW'(pa[0]) + qvr_pkg::TermW'(pa[1]) - qvr_pkg::TermW'(pa[2]);
      ty   <= qvr_pkg::TermW'(pa[3]) + qvr_pkg::TermW'(pa[4]) - qvr_pkg::TermW'(pa[5]);
      tz   <= qvr_pkg::TermW'(pa[6]) + qvr_pkg::TermW'(pa[7]) - qvr_pkg::TermW'(pa[8]);
      td   <= qvr_pkg::TermW'(pa[9]) + qvr_pkg::TermW'(pa[10]) + qvr_pkg::TermW'(pa[11]);
      qb_x <= qa_x;
      qb_y <= qa_y;
      qb_z <= qa_z;
      qb_w <= qa_w;
    end
  end

  // t * conj(q) products
  always_ff @(posedge clk) begin
    if (en_c) begin
      pc[0]  <= qvr_pkg::mul_c(td, qb_x);
      pc[1]  <= qvr_pkg::mul_c(tx, qb_w);
      pc[2]  <= qvr_pkg::mul_c(ty, qb_z);
      pc[3]  <= qvr_pkg::mul_c(tz, qb_y);
      pc[4]  <= qvr_pkg::mul_c(td, qb_y);
      pc[5]  <= qvr_pkg::mul_c(ty, qb_w);
      pc[6]  <= qvr_pkg::mul_c(tz, qb_x);
      pc[7]  <= qvr_pkg::mul_c(tx, qb_z);
      pc[8]  <= qvr_pkg::mul_c(td, qb_z);
      pc[9]  <= qvr_pkg::mul_c(tz, qb_w);
      pc[10] <= qvr_pkg::mul_c(tx, qb_y);
      pc[11] <= qvr_pkg::mul_c(ty, qb_x);
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      rd.x <= qvr_pkg::round_down(qvr_pkg::SumW'(pc[0]) + qvr_pkg::SumW'(pc[1])
                                  - qvr_pkg::SumW'(pc[2]) + qvr_pkg::SumW'(pc[3]));
      rd.y <= qvr_pkg::round_down(qvr_pkg::SumW'(pc[4]) + qvr_pkg::SumW'(pc[5])
                                  - qvr_pkg::SumW'(pc[6]) + qvr_pkg::SumW'(pc[7]));
      rd.z <= qvr_pkg::round_down(qvr_pkg::SumW'(pc[8]) + qvr_pkg::SumW'(pc[9])
                                  - qvr_pkg::SumW'(pc[10]) + qvr_pkg::SumW'(pc[11]));
    end
  end

  qvr_sat u_sat (
    .r   (rd),
    .rot (rot_next)
  );

  always_ff @(posedge clk) begin
    if (en_e) begin
      rot <= rot_next;
    end
  end

  assign out_valid = v_e;
  assign rot_x     = rot.x;
  assign rot_y     = rot.y;
  assign rot_z     = rot.z;
  assign clipped   = rot.clip;

`ifndef ASSERT_OFF
  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      rot_x == qvr_pkg::OutMax || rot_x == qvr_pkg::OutMin ||
      rot_y == qvr_pkg::OutMax || rot_y == qvr_pkg::OutMin ||
      rot_z == qvr_pkg::OutMax || rot_z == qvr_pkg::OutMin)
    else $error("clipped without a saturated component");

  a_stall_holds_c: assert property (@(posedge clk) disable iff (rst)
    v_c && !en_c |=> v_c && $stable(pc[0]) && $stable(pc[11]))
    else $error("stalled product stage lost its word");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v_a)
    else $error("accepted word not captured");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> v_a && v_b && v_c && v_d && v_e && !out_ready)
    else $error("input stalled with a free stage");
`endif

endmodule
